@@ rtl/ghpff_pkg.sv @@
// ----------------------------------------------------------------------------
// ghpff_pkg
// Shared types, codes and defaults for the generational handle pool.
// ----------------------------------------------------------------------------
`default_nettype none

package ghpff_pkg;

    localparam int GHPFF_SLOT_COUNT  = 64;
    localparam int GHPFF_QUEUE_DEPTH = 16;

    localparam logic [15:0] MAX_SIDE_RESET = 16'd16384;
    localparam logic [31:0] GEN_MAX        = 32'hFFFF_FFFF;

    // Field widths of the stream beats.
    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        K_CREATE  = 2'd0,
        K_DESTROY = 2'd1,
        K_COLLECT = 2'd2,
        K_CHECK   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NOT_READY     = 3'd1,
        ST_INVALID       = 3'd2,
        ST_GEN_EXHAUSTED = 3'd3,
        ST_NO_SPACE      = 3'd4,
        ST_NOT_FOUND     = 3'd5,
        ST_BACKEND       = 3'd6
    } t_status;

    localparam logic [2:0] RT_BUFFER   = 3'd1;
    localparam logic [2:0] RT_TEXTURE  = 3'd2;
    localparam logic [2:0] RT_TARGET   = 3'd3;
    localparam logic [2:0] RT_SAMPLER  = 3'd4;
    localparam logic [2:0] RT_PIPELINE = 3'd5;

    localparam logic CFG_DEVICE_READY = 1'b0;
    localparam logic CFG_MAX_SIDE     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_SCAN,
        S_GRD,
        S_GEV,
        S_HRD,
        S_HEV,
        S_QRD,
        S_QEV,
        S_QFIN
    } t_state;

    typedef struct packed {
        logic [4:0]  count;
        logic        alive;
        logic [2:0]  kind;
        logic [31:0] gen;
        logic [5:0]  slot;
        t_status     status;
        logic        last;
    } t_result;

    function automatic t_result mk_result(input t_status st);
        t_result r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ghpff_ram.sv @@
// ----------------------------------------------------------------------------
// ghpff_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghpff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/generational_handle_pool_fenced_free_unit.sv @@
// ----------------------------------------------------------------------------
// generational_handle_pool_fenced_free_unit
// Generational handle pool with fence-deferred release of destroyed handles.
// ----------------------------------------------------------------------------
// One command is taken at a time; the input is ready only while the unit is
// idle, and a finished result may wait in the output register while the next
// command is already accepted. A check or destroy makes one read of the
// generation memory. A create scans groups of eight slots, lowest first, for
// a slot in use that is neither alive nor pending; it reuses such a slot
// with a bumped generation after one read of the generation memory, or else
// appends a fresh slot at generation zero. A collect walks the release queue
// through its memory and gives one beat per released handle, or a single
// beat when none is released. Output back-pressure stalls the unit while a
// result waits to be emitted. Slot generations and types live in one memory,
// queued handles and their fences in another; neither needs clearing after
// reset because every entry is written before its contents are used.
`default_nettype none

module generational_handle_pool_fenced_free_unit #(
    parameter int SLOT_COUNT  = ghpff_pkg::GHPFF_SLOT_COUNT,
    parameter int QUEUE_DEPTH = ghpff_pkg::GHPFF_QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_addr,
    input  wire logic [15:0]                        i_cfg_wdata,
    // Command stream.
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata, from bit 0 up: res_type, buffer_bytes, tex_width, tex_height,
    // backend_ok, handle_slot, handle_gen, handle_kind, retire_fence,
    // completed_fence, zero fill.
    input  wire logic [ghpff_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // tuser: kind.
    input  wire logic [1:0]                         i_s_tuser,
    // Result stream.
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata, from bit 0 up: status, out_slot, out_gen, out_kind, alive,
    // released_count, zero fill.
    output logic [ghpff_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                    o_m_tlast
);

    import ghpff_pkg::*;

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int SU   = $clog2(SLOT_COUNT + 1);
    localparam int GW   = (SW > 3) ? SW - 3 : 1;
    localparam int PW   = GW + 3;
    localparam int PAD  = 1 << PW;
    localparam int QA   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QW1  = $clog2(QUEUE_DEPTH + 1);
    localparam int GEW  = 35;
    localparam int QEW  = SW + 99;

    // Latched command fields.
    logic [2:0]  r_type;
    logic        r_bok;
    logic [5:0]  r_hslot;
    logic [31:0] r_hgen;
    logic [2:0]  r_hkind;
    logic [63:0] r_retire;
    logic [63:0] r_cfence;
    logic        r_is_check;

    // Configuration.
    logic        r_dev_ready;
    logic [15:0] r_max_side;

    // Control state.
    t_state          r_state,      n_state;
    logic [PAD-1:0]  r_alive,      n_alive;
    logic [PAD-1:0]  r_pend,       n_pend;
    logic [SU-1:0]   r_siu,        n_siu;
    logic [QW1-1:0]  r_qcount,     n_qcount;
    logic [QW1-1:0]  r_qi,         n_qi;
    logic [QW1-1:0]  r_kept,       n_kept;
    logic [QW1-1:0]  r_rel,        n_rel;
    logic [GW-1:0]   r_grp,        n_grp;
    logic [SW-1:0]   r_idx,        n_idx;
    logic [SW-1:0]   r_raddr,      n_raddr;
    logic            r_out_valid,  n_out_valid;
    logic            r_hold_valid, n_hold_valid;
    t_result         r_out,        n_out;
    t_result         r_res,        n_res;
    t_result         r_hold,       n_hold;

    // Memory ports.
    logic            g_we;
    logic [SW-1:0]   g_waddr;
    logic [GEW-1:0]  g_wdata;
    logic [GEW-1:0]  g_rdata;
    logic            q_we;
    logic [QA-1:0]   q_waddr;
    logic [QEW-1:0]  q_wdata;
    logic [QEW-1:0]  q_rdata;

    logic s_accept;
    logic out_free;
    logic desc_ok;
    logic [7:0]    grp_free;
    logic [PW-1:0] h_pidx;
    logic          live;
    logic [31:0]   next_start;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign h_pidx   = PW'(r_hslot);

    ghpff_ram #(.WIDTH(GEW), .DEPTH(SLOT_COUNT), .AW(SW)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (r_raddr),
        .o_rdata (g_rdata)
    );

    ghpff_ram #(.WIDTH(QEW), .DEPTH(QUEUE_DEPTH), .AW(QA)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (r_qi[QA-1:0]),
        .o_rdata (q_rdata)
    );

    // Descriptor check on the incoming beat.
    always_comb begin
        logic [2:0]  ty;
        logic [15:0] tw;
        logic [15:0] th;
        ty = i_s_tdata[2:0];
        tw = i_s_tdata[50:35];
        th = i_s_tdata[66:51];
        unique case (ty)
            RT_BUFFER:   desc_ok = (i_s_tdata[34:3] != 32'd0);
            RT_TEXTURE,
            RT_TARGET:   desc_ok = (tw != 16'd0) && (tw <= r_max_side) &&
                                   (th != 16'd0) && (th <= r_max_side);
            RT_SAMPLER,
            RT_PIPELINE: desc_ok = 1'b1;
            default:     desc_ok = 1'b0;
        endcase
    end

    // Free-slot flags for the eight slots of the current scan group.
    always_comb begin
        logic [PW-1:0] pi;
        for (int j = 0; j < 8; j++) begin
            pi          = {r_grp, 3'(j)};
            grp_free[j] = (32'(pi) < 32'(r_siu)) && !r_alive[pi] && !r_pend[pi];
        end
        next_start = 32'({r_grp, 3'b000}) + 32'd8;
    end

    // Liveness of the latched handle against the generation memory output.
    assign live = (r_hkind != 3'd0) && (32'(r_hslot) < 32'(r_siu)) &&
                  r_alive[h_pidx] && (g_rdata[31:0] == r_hgen) &&
                  (g_rdata[34:32] == r_hkind);

    always_comb begin
        logic [2:0]     fnd_j;
        logic           fnd;
        logic [PW-1:0]  ai;
        logic [PW-1:0]  qs;
        logic [31:0]    ngen;
        t_result        rr;

        n_state      = r_state;
        n_alive      = r_alive;
        n_pend       = r_pend;
        n_siu        = r_siu;
        n_qcount     = r_qcount;
        n_qi         = r_qi;
        n_kept       = r_kept;
        n_rel        = r_rel;
        n_grp        = r_grp;
        n_idx        = r_idx;
        n_raddr      = r_raddr;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_m_tready;
        g_we         = 1'b0;
        g_waddr      = r_idx;
        g_wdata      = {r_type, 32'd0};
        q_we         = 1'b0;
        q_waddr      = r_qcount[QA-1:0];
        q_wdata      = {SW'(r_hslot), r_hgen, r_hkind, r_retire};
        fnd          = 1'b0;
        fnd_j        = 3'd0;
        ai           = {r_grp, 3'b000};
        qs           = PW'(q_rdata[QEW-1:99]);
        ngen         = g_rdata[31:0] + 32'd1;
        rr           = '0;
        o_s_tready   = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_raddr = SW'(i_s_tdata[73:68]);
                    unique case (t_kind'(i_s_tuser))
                        K_CREATE: begin
                            n_grp = '0;
                            if (!r_dev_ready) begin
                                n_res   = mk_result(ST_NOT_READY);
                                n_state = S_EMIT;
                            end else if (!desc_ok) begin
                                n_res   = mk_result(ST_INVALID);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        K_DESTROY, K_CHECK: begin
                            if (!r_dev_ready && (t_kind'(i_s_tuser) == K_DESTROY)) begin
                                n_res   = mk_result(ST_NOT_READY);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_HRD;
                            end
                        end
                        K_COLLECT: begin
                            n_qi         = '0;
                            n_kept       = '0;
                            n_rel        = '0;
                            n_hold_valid = 1'b0;
                            if (!r_dev_ready) begin
                                n_res   = mk_result(ST_NOT_READY);
                                n_state = S_EMIT;
                            end else if (r_qcount == '0) begin
                                n_res   = mk_result(ST_OK);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_QRD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // Scan eight slots a cycle for the lowest free one.
            S_SCAN: begin
                for (int j = 7; j >= 0; j--) begin
                    if (grp_free[j]) begin
                        fnd   = 1'b1;
                        fnd_j = 3'(j);
                    end
                end
                if (fnd) begin
                    n_idx   = SW'({r_grp, fnd_j});
                    n_raddr = SW'({r_grp, fnd_j});
                    n_state = S_GRD;
                end else if (next_start < 32'(r_siu)) begin
                    n_grp = r_grp + GW'(1);
                end else if (32'(r_siu) >= 32'(SLOT_COUNT)) begin
                    n_res   = mk_result(ST_NO_SPACE);
                    n_state = S_EMIT;
                end else begin
                    // Append a fresh slot at generation zero.
                    ai          = PW'(r_siu);
                    g_we        = 1'b1;
                    g_waddr     = SW'(r_siu);
                    g_wdata     = {r_type, 32'd0};
                    n_siu       = r_siu + SU'(1);
                    n_pend[ai]  = 1'b0;
                    n_alive[ai] = r_bok;
                    if (r_bok) begin
                        rr        = mk_result(ST_OK);
                        rr.slot   = 6'(r_siu);
                        rr.kind   = r_type;
                        n_res     = rr;
                    end else begin
                        n_res = mk_result(ST_BACKEND);
                    end
                    n_state = S_EMIT;
                end
            end

            S_GRD: n_state = S_GEV;

            // Reuse the found slot with a bumped generation, unless its generation is exhausted.
            S_GEV: begin
                ai = PW'(r_idx);
                if (g_rdata[31:0] == GEN_MAX) begin
                    n_res = mk_result(ST_GEN_EXHAUSTED);
                end else begin
                    g_we        = 1'b1;
                    g_waddr     = r_idx;
                    g_wdata     = {r_type, ngen};
                    n_alive[ai] = r_bok;
                    if (r_bok) begin
                        rr      = mk_result(ST_OK);
                        rr.slot = 6'(r_idx);
                        rr.gen  = ngen;
                        rr.kind = r_type;
                        n_res   = rr;
                    end else begin
                        n_res = mk_result(ST_BACKEND);
                    end
                end
                n_state = S_EMIT;
            end

            S_HRD: n_state = S_HEV;

            S_HEV: begin
                if (r_is_check) begin
                    rr       = mk_result(ST_OK);
                    rr.alive = live;
                    n_res    = rr;
                end else if (!live) begin
                    n_res = mk_result(ST_NOT_FOUND);
                end else if (32'(r_qcount) >= 32'(QUEUE_DEPTH)) begin
                    n_res = mk_result(ST_NO_SPACE);
                end else begin
                    n_alive[h_pidx] = 1'b0;
                    n_pend[h_pidx]  = 1'b1;
                    q_we            = 1'b1;
                    n_qcount        = r_qcount + QW1'(1);
                    n_res           = mk_result(ST_OK);
                end
                n_state = S_EMIT;
            end

            S_QRD: n_state = S_QEV;

            // Release or compact one queue entry.
            S_QEV: begin
                if (q_rdata[63:0] <= r_cfence) begin
                    if (!r_hold_valid || out_free) begin
                        if (r_hold_valid) begin
                            n_out       = r_hold;
                            n_out_valid = 1'b1;
                        end
                        rr           = '0;
                        rr.status    = ST_OK;
                        rr.slot      = 6'(q_rdata[QEW-1:99]);
                        rr.gen       = q_rdata[98:67];
                        rr.kind      = q_rdata[66:64];
                        n_hold       = rr;
                        n_hold_valid = 1'b1;
                        n_rel        = r_rel + QW1'(1);
                        n_pend[qs]   = 1'b0;
                        n_qi         = r_qi + QW1'(1);
                        n_state      = (r_qi + QW1'(1) == r_qcount) ? S_QFIN : S_QRD;
                    end
                end else begin
                    q_we    = 1'b1;
                    q_waddr = r_kept[QA-1:0];
                    q_wdata = q_rdata;
                    n_kept  = r_kept + QW1'(1);
                    n_qi    = r_qi + QW1'(1);
                    n_state = (r_qi + QW1'(1) == r_qcount) ? S_QFIN : S_QRD;
                end
            end

            S_QFIN: begin
                n_qcount = r_kept;
                if (out_free) begin
                    if (r_hold_valid) begin
                        rr       = r_hold;
                        rr.last  = 1'b1;
                        rr.count = 5'(r_rel);
                        n_out    = rr;
                    end else begin
                        n_out = mk_result(ST_OK);
                    end
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_alive      <= '0;
            r_pend       <= '0;
            r_siu        <= '0;
            r_qcount     <= '0;
            r_qi         <= '0;
            r_kept       <= '0;
            r_rel        <= '0;
            r_grp        <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
            r_dev_ready  <= 1'b0;
            r_max_side   <= MAX_SIDE_RESET;
        end else begin
            r_state      <= n_state;
            r_alive      <= n_alive;
            r_pend       <= n_pend;
            r_siu        <= n_siu;
            r_qcount     <= n_qcount;
            r_qi         <= n_qi;
            r_kept       <= n_kept;
            r_rel        <= n_rel;
            r_grp        <= n_grp;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_DEVICE_READY: r_dev_ready <= i_cfg_wdata[0];
                    CFG_MAX_SIDE:     r_max_side  <= i_cfg_wdata;
                    default:          r_dev_ready <= r_dev_ready;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_raddr <= n_raddr;
        r_res   <= n_res;
        r_out   <= n_out;
        r_hold  <= n_hold;
        if (s_accept) begin
            r_type     <= i_s_tdata[2:0];
            r_bok      <= i_s_tdata[67];
            r_hslot    <= i_s_tdata[73:68];
            r_hgen     <= i_s_tdata[105:74];
            r_hkind    <= i_s_tdata[108:106];
            r_retire   <= i_s_tdata[172:109];
            r_cfence   <= i_s_tdata[236:173];
            r_is_check <= (t_kind'(i_s_tuser) == K_CHECK);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {6'd0, r_out.count, r_out.alive, r_out.kind, r_out.gen,
                         r_out.slot, r_out.status};

endmodule

`default_nettype wire

@@ rtl/ghpff_checker.sv @@
// ----------------------------------------------------------------------------
// ghpff_checker
// Port-level checks for the generational handle pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ghpff_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [ghpff_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                             o_m_tlast
);

    import ghpff_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("unit not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("command accepted while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] != 3'd7))
        else $error("undefined status code");

    a_mid_beat_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |->
            ((o_m_tdata[2:0] == ST_OK) && !o_m_tdata[44] && (o_m_tdata[49:45] == 5'd0)))
        else $error("non-final beat is not a plain release");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind generational_handle_pool_fenced_free_unit ghpff_checker u_ghpff_checker (.*);

`default_nettype wire
